[hw/rtl/sfmc_pkg.sv]
package sfmc_pkg;

   localparam int unsigned HOUR_W     = 5;
   localparam int unsigned MINUTE_W   = 6;
   localparam int unsigned TIMEOUT_W  = 20;
   localparam int unsigned DEBOUNCE_W = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned DUTY_W     = 8;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 20;

   localparam logic [DUTY_W-1:0] RUN_DUTY = 8'd130;

   // Register reset values.
   localparam logic [HOUR_W-1:0]     FEED_HOUR_RST   = 5'd8;
   localparam logic [MINUTE_W-1:0]   FEED_MINUTE_RST = 6'd0;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST     = 20'd10000;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST    = 16'd50;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FEED_HOUR   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEED_MINUTE = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE    = 8'd3;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_MINUTE = 2'd1,
      KIND_MANUAL = 2'd2,
      KIND_HALL   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      EVT_NONE    = 2'd0,
      EVT_STARTED = 2'd1,
      EVT_STOPPED = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_HALL    = 2'd1,
      CAUSE_TIMEOUT = 2'd2
   } cause_type;

   typedef struct packed {
      kind_type            kind;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic                auto_enabled;
   } req_type;

   typedef struct packed {
      logic               motor_on;
      logic [DUTY_W-1:0]  pwm_duty;
      logic [COUNT_W-1:0] feed_tally;
      event_type          state_event;
      cause_type          stop_cause;
      logic               manual_ignored;
   } rsp_type;

   typedef struct packed {
      logic [HOUR_W-1:0]     feed_hour;
      logic [MINUTE_W-1:0]   feed_minute;
      logic [TIMEOUT_W-1:0]  run_limit;
      logic [DEBOUNCE_W-1:0] hall_guard;
   } cfg_type;

endpackage

[hw/rtl/scheduled_feeder_motor_controller.sv]
// The result of an accepted item is registered and shows in the next cycle.
// Throughput: one item per cycle, set by the single output register; the input
// stalls only while a result is held there and the result side stalls.
// Reset (synchronous, active high) zeroes the controller state, empties the
// output register and loads the configuration registers with their defaults.
module scheduled_feeder_motor_controller
   import sfmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;
   rsp_type rsp_next;
   logic    req_accept;

   // The output register is the only buffering: an item can enter whenever
   // the held result leaves in the same cycle or the register is empty.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Configuration is always writable; writes to indexes beyond the register
   // list are taken and dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FEED_HOUR:   cfg_in.feed_hour   = csr_data[HOUR_W-1:0];
            CSR_FEED_MINUTE: cfg_in.feed_minute = csr_data[MINUTE_W-1:0];
            CSR_TIMEOUT:     cfg_in.run_limit   = csr_data[TIMEOUT_W-1:0];
            CSR_DEBOUNCE:    cfg_in.hall_guard  = csr_data[DEBOUNCE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feed_hour   <= FEED_HOUR_RST;
         cfg_ff.feed_minute <= FEED_MINUTE_RST;
         cfg_ff.run_limit   <= TIMEOUT_RST;
         cfg_ff.hall_guard  <= DEBOUNCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // All event decoding and the state update happen in one pass inside the
   // core; its state advances only on an accepted item.
   sfmc_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (req_accept),
      .req   (req_payload),
      .cfg   (cfg_ff),
      .rsp   (rsp_next)
   );

   // The result register holds while stalled and reloads on every accepted item.
   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[hw/rtl/sfmc_core.sv]
module sfmc_core
   import sfmc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic [TIME_W-1:0]  ms_counter_ff, ms_counter_in;
   logic               motor_running_ff, motor_running_in;
   logic               hall_pending_ff, hall_pending_in;
   logic [TIME_W-1:0]  start_time_ff, start_time_in;
   logic [TIME_W-1:0]  last_hall_time_ff, last_hall_time_in;
   logic               fed_today_ff, fed_today_in;
   logic [COUNT_W-1:0] feeds_done_ff, feeds_done_in;

   logic [TIME_W-1:0]  run_elapsed;
   logic [TIME_W-1:0]  hall_gap;
   logic [COUNT_W-1:0] feeds_inc;
   logic               sched_match;
   logic               midnight;
   event_type          evt;
   cause_type          cause;
   logic               ignored;

   // Run time as seen after this tick advances the millisecond counter.
   assign run_elapsed = ms_counter_ff + TIME_W'(1) - start_time_ff;
   assign hall_gap    = ms_counter_ff - last_hall_time_ff;
   assign feeds_inc   = (feeds_done_ff == {COUNT_W{1'b1}}) ? feeds_done_ff
                                                           : feeds_done_ff + COUNT_W'(1);
   assign sched_match = req.auto_enabled && (req.hour == cfg.feed_hour)
                        && (req.minute == cfg.feed_minute) && !fed_today_ff;
   assign midnight    = (req.hour == '0) && (req.minute == '0);

   always_comb begin
      ms_counter_in     = ms_counter_ff;
      motor_running_in  = motor_running_ff;
      hall_pending_in   = hall_pending_ff;
      start_time_in     = start_time_ff;
      last_hall_time_in = last_hall_time_ff;
      fed_today_in      = fed_today_ff;
      feeds_done_in     = feeds_done_ff;
      evt               = EVT_NONE;
      cause             = CAUSE_NONE;
      ignored           = 1'b0;
      case (req.kind)
         KIND_TICK: begin
            ms_counter_in = ms_counter_ff + TIME_W'(1);
            if (motor_running_ff && hall_pending_ff) begin
               motor_running_in = 1'b0;
               hall_pending_in  = 1'b0;
               feeds_done_in    = feeds_inc;
               evt              = EVT_STOPPED;
               cause            = CAUSE_HALL;
            end else if (motor_running_ff
                         && (run_elapsed > TIME_W'(cfg.run_limit))) begin
               motor_running_in = 1'b0;
               feeds_done_in    = feeds_inc;
               evt              = EVT_STOPPED;
               cause            = CAUSE_TIMEOUT;
            end
         end
         KIND_MINUTE: begin
            if (sched_match) begin
               fed_today_in = 1'b1;
               if (!motor_running_ff) begin
                  motor_running_in = 1'b1;
                  hall_pending_in  = 1'b0;
                  start_time_in    = ms_counter_ff;
                  evt              = EVT_STARTED;
               end
            end
            // The midnight clear wins over a scheduled feed set at 00:00.
            if (midnight) begin
               fed_today_in  = 1'b0;
               feeds_done_in = '0;
            end
         end
         KIND_MANUAL: begin
            if (req.auto_enabled) begin
               ignored = 1'b1;
            end else if (!motor_running_ff) begin
               motor_running_in = 1'b1;
               hall_pending_in  = 1'b0;
               start_time_in    = ms_counter_ff;
               evt              = EVT_STARTED;
            end
         end
         KIND_HALL: begin
            if (motor_running_ff && (hall_gap > TIME_W'(cfg.hall_guard))) begin
               hall_pending_in   = 1'b1;
               last_hall_time_in = ms_counter_ff;
            end
         end
         default: begin
            ms_counter_in = ms_counter_ff;
         end
      endcase
   end

   always_comb begin
      rsp.motor_on       = motor_running_in;
      rsp.pwm_duty       = motor_running_in ? RUN_DUTY : '0;
      rsp.feed_tally     = feeds_done_in;
      rsp.state_event    = evt;
      rsp.stop_cause     = cause;
      rsp.manual_ignored = ignored;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_counter_ff     <= '0;
         motor_running_ff  <= 1'b0;
         hall_pending_ff   <= 1'b0;
         start_time_ff     <= '0;
         last_hall_time_ff <= '0;
         fed_today_ff      <= 1'b0;
         feeds_done_ff     <= '0;
      end else if (step) begin
         ms_counter_ff     <= ms_counter_in;
         motor_running_ff  <= motor_running_in;
         hall_pending_ff   <= hall_pending_in;
         start_time_ff     <= start_time_in;
         last_hall_time_ff <= last_hall_time_in;
         fed_today_ff      <= fed_today_in;
         feeds_done_ff     <= feeds_done_in;
      end
   end

endmodule

[hw/rtl/sfmc_checker.sv]
module sfmc_checker
   import sfmc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // The duty follows the motor state in every result.
   a_duty_matches_motor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.motor_on && rsp_payload.pwm_duty == RUN_DUTY)
                     || (!rsp_payload.motor_on && rsp_payload.pwm_duty == '0)))
      else $error("pwm duty does not match motor state");

   // A stop leaves the motor off with a cause; a start leaves it on with none.
   a_event_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_payload.state_event == EVT_STOPPED && !rsp_payload.motor_on
           && rsp_payload.stop_cause != CAUSE_NONE)
          || (rsp_payload.state_event == EVT_STARTED && rsp_payload.motor_on
              && rsp_payload.stop_cause == CAUSE_NONE)
          || (rsp_payload.state_event == EVT_NONE
              && rsp_payload.stop_cause == CAUSE_NONE)))
      else $error("state event and stop cause disagree");

   // Back pressure reaches the input only through a held result.
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // An accepted item always shows up as a result in the next cycle.
   a_item_to_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item produced no result");

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

endmodule

bind scheduled_feeder_motor_controller sfmc_checker u_sfmc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[verif/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfmc_pkg::*;

   // A stretch this long with no item moving on any port means the block hung.
   localparam int WATCHDOG_LIMIT = 5000;
   // The stimulus thread stays at most this far ahead of the driver.
   localparam int PENDING_DEPTH = 32;
   // Quiet cycles after the last result.
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PER_PHASE = 98;
   localparam int PHASE_COUNT = 8;
   // Register indexes that lie past the implemented set.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW = CSR_DEBOUNCE + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_TOP = '1;

   typedef struct {
      req_type item;
      bit      drain;
   } pending_event_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Items waiting to be driven, and the status expected for every accepted item.
   pending_event_type pending_events[$];
   rsp_type           expected_status[$];

   // Handshake bookkeeping shared between the edge-sampling and driving blocks.
   bit req_taken = 1'b0;
   int idle_cycles = 0;
   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   // Feed time of the current phase, used to aim minute updates at a match.
   logic [HOUR_W-1:0]   sched_hour = FEED_HOUR_RST;
   logic [MINUTE_W-1:0] sched_minute = FEED_MINUTE_RST;

   // Shadow copy of the controller: registers and running state.
   cfg_type             regs;
   logic [TIME_W-1:0]   now_ms;
   logic [TIME_W-1:0]   run_start;
   logic [TIME_W-1:0]   last_edge_ms;
   logic                running;
   logic                stop_armed;
   logic                fed_flag;
   logic [COUNT_W-1:0]  feed_total;

   scheduled_feeder_motor_controller DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A start only takes effect while the motor is stopped. It disarms any
   // pending hall stop and marks the start time for the timeout.
   function automatic bit start_motor();
      if (running) begin
         return 1'b0;
      end
      running = 1'b1;
      stop_armed = 1'b0;
      run_start = now_ms;
      return 1'b1;
   endfunction

   // Every stop counts as one completed feed; the count sticks at its maximum.
   function automatic void stop_motor();
      running = 1'b0;
      if (feed_total != '1) begin
         feed_total = feed_total + 1'b1;
      end
   endfunction

   // Advances the shadow state by one item and returns the status the block
   // must report for it.
   function automatic rsp_type predict_status(req_type r);
      rsp_type           o;
      logic [TIME_W-1:0] elapsed;
      o = '0;
      o.state_event = EVT_NONE;
      o.stop_cause = CAUSE_NONE;
      case (r.kind)
         KIND_TICK: begin
            // Time moves first. An armed hall stop wins over the timeout,
            // and a tick stops the motor at most once. Differences wrap.
            now_ms = now_ms + 1'b1;
            elapsed = now_ms - run_start;
            if (running && stop_armed) begin
               stop_motor();
               stop_armed = 1'b0;
               o.state_event = EVT_STOPPED;
               o.stop_cause = CAUSE_HALL;
            end else if (running && elapsed > TIME_W'(regs.run_limit)) begin
               stop_motor();
               o.state_event = EVT_STOPPED;
               o.stop_cause = CAUSE_TIMEOUT;
            end
         end
         KIND_MINUTE: begin
            // A scheduled match marks the day as fed even when the motor is
            // already running. The midnight clear comes after the match, so
            // a 00:00 feed time starts the motor and then forgets it fed.
            if (r.auto_enabled && r.hour == regs.feed_hour &&
                r.minute == regs.feed_minute && !fed_flag) begin
               if (start_motor()) begin
                  o.state_event = EVT_STARTED;
               end
               fed_flag = 1'b1;
            end
            if (r.hour == '0 && r.minute == '0) begin
               fed_flag = 1'b0;
               feed_total = '0;
            end
         end
         KIND_MANUAL: begin
            if (r.auto_enabled) begin
               o.manual_ignored = 1'b1;
            end else if (start_motor()) begin
               o.state_event = EVT_STARTED;
            end
         end
         default: begin
            // A hall edge only counts while running and outside the debounce
            // window; an ignored edge leaves the debounce time alone.
            elapsed = now_ms - last_edge_ms;
            if (running && elapsed > TIME_W'(regs.hall_guard)) begin
               stop_armed = 1'b1;
               last_edge_ms = now_ms;
            end
         end
      endcase
      o.motor_on = running;
      o.pwm_duty = running ? RUN_DUTY : '0;
      o.feed_tally = feed_total;
      return o;
   endfunction

   // Prints one line per failure and counts it.
   task automatic report_error(input string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      errors++;
   endtask

   // Everything is sampled at the rising edge. Outputs of the block still hold
   // their pre-edge values here, so the sampled handshakes are the real ones.
   always @(posedge clock) begin : watch_ports
      rsp_type want;
      bit      rsp_fire;
      bit      csr_fire;
      if (reset) begin
         regs.feed_hour = FEED_HOUR_RST;
         regs.feed_minute = FEED_MINUTE_RST;
         regs.run_limit = TIMEOUT_RST;
         regs.hall_guard = DEBOUNCE_RST;
         now_ms = '0;
         run_start = '0;
         last_edge_ms = '0;
         running = 1'b0;
         stop_armed = 1'b0;
         fed_flag = 1'b0;
         feed_total = '0;
         expected_status.delete();
         req_taken = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_valid && !req_stall;
         rsp_fire = rsp_valid && !rsp_stall;
         csr_fire = csr_valid && csr_ready;

         // Each result is matched against the oldest outstanding item.
         if (rsp_fire) begin
            if (expected_status.size() == 0) begin
               report_error("result arrived with no item outstanding");
            end else begin
               want = expected_status.pop_front();
               if (rsp_payload.motor_on !== want.motor_on)
                  report_error($sformatf("motor_on got %0d expected %0d",
                                         rsp_payload.motor_on, want.motor_on));
               if (rsp_payload.pwm_duty !== want.pwm_duty)
                  report_error($sformatf("pwm_duty got %0d expected %0d",
                                         rsp_payload.pwm_duty, want.pwm_duty));
               if (rsp_payload.feed_tally !== want.feed_tally)
                  report_error($sformatf("feed_tally got %0d expected %0d",
                                         rsp_payload.feed_tally, want.feed_tally));
               if (rsp_payload.state_event !== want.state_event)
                  report_error($sformatf("state_event got %0d expected %0d",
                                         rsp_payload.state_event, want.state_event));
               if (rsp_payload.stop_cause !== want.stop_cause)
                  report_error($sformatf("stop_cause got %0d expected %0d",
                                         rsp_payload.stop_cause, want.stop_cause));
               if (rsp_payload.manual_ignored !== want.manual_ignored)
                  report_error($sformatf("manual_ignored got %0d expected %0d",
                                         rsp_payload.manual_ignored,
                                         want.manual_ignored));
            end
         end

         if (req_taken) begin
            expected_status.push_back(predict_status(req_payload));
         end

         // Register writes land in the shadow copy at the same edge as in the
         // block. Indexes past the implemented set change nothing.
         if (csr_fire) begin
            case (csr_index)
               CSR_FEED_HOUR:   regs.feed_hour = csr_data[HOUR_W-1:0];
               CSR_FEED_MINUTE: regs.feed_minute = csr_data[MINUTE_W-1:0];
               CSR_TIMEOUT:     regs.run_limit = csr_data[TIMEOUT_W-1:0];
               CSR_DEBOUNCE:    regs.hall_guard = csr_data[DEBOUNCE_W-1:0];
               default: ;
            endcase
         end

         if (req_taken || rsp_fire || csr_fire) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   // The driver works on the falling edge. A new item is presented only when
   // the channel is free or the current item was just taken, so a stalled
   // payload never moves. An item flagged for draining waits until every
   // earlier result has come back.
   always @(negedge clock) begin : drive_events
      logic    next_valid;
      req_type next_item;
      next_valid = req_valid;
      next_item = req_payload;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
             (!pending_events[0].drain || expected_status.size() == 0)) begin
            next_item = pending_events[0].item;
            void'(pending_events.pop_front());
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
      req_payload <= next_item;
   end

   // The result side stalls at random, at the rate set for the phase.
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic req_type make_event(kind_type k, int hour, int minute, bit auto_on);
      req_type r;
      r.kind = k;
      r.hour = HOUR_W'(hour);
      r.minute = MINUTE_W'(minute);
      r.auto_enabled = auto_on;
      return r;
   endfunction

   // Any kind with fully random fields. Minute updates are steered toward the
   // feed time and midnight often enough that scheduled starts and clears
   // actually happen; the rest land anywhere, out-of-range values included.
   function automatic req_type random_event();
      req_type     r;
      int unsigned pick;
      r.kind = kind_type'($urandom_range(0, 3));
      r.hour = HOUR_W'($urandom_range(0, 31));
      r.minute = MINUTE_W'($urandom_range(0, 63));
      r.auto_enabled = 1'($urandom_range(0, 1));
      if (r.kind == KIND_MINUTE) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            r.hour = sched_hour;
            r.minute = sched_minute;
         end else if (pick < 6) begin
            r.hour = '0;
            r.minute = '0;
         end else if (pick < 9) begin
            r.hour = HOUR_W'($urandom_range(0, 23));
            r.minute = MINUTE_W'($urandom_range(0, 59));
         end
      end
      return r;
   endfunction

   task automatic queue_item(input req_type r, input bit drain);
      pending_event_type p;
      while (pending_events.size() >= PENDING_DEPTH) begin
         @(posedge clock);
      end
      p.item = r;
      p.drain = drain;
      pending_events.push_back(p);
   endtask

   // One feed cycle: something that tries to start the motor, then a run of
   // ticks and hall edges that can stop it, with some unrelated items mixed in.
   task automatic feed_sequence(inout int count);
      req_type     r;
      int unsigned pick;
      int          len;
      r = random_event();
      case ($urandom_range(0, 3))
         0, 1: begin
            r.kind = KIND_MANUAL;
            r.auto_enabled = 1'b0;
         end
         2: begin
            r.kind = KIND_MINUTE;
            r.hour = sched_hour;
            r.minute = sched_minute;
            r.auto_enabled = 1'b1;
         end
         default: begin
            r.kind = KIND_MINUTE;
            r.hour = '0;
            r.minute = '0;
         end
      endcase
      queue_item(r, count == RANDOM_PER_PHASE / 2 || $urandom_range(0, 199) == 0);
      count++;
      len = $urandom_range(2, 16);
      repeat (len) begin
         r = random_event();
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            r.kind = KIND_TICK;
         end else if (pick < 82) begin
            r.kind = KIND_HALL;
         end
         queue_item(r, count == RANDOM_PER_PHASE / 2 || $urandom_range(0, 199) == 0);
         count++;
      end
   endtask

   // Returns once every queued item has been taken and answered.
   task automatic wait_drained();
      @(posedge clock);
      #1;
      while (pending_events.size() != 0 || req_valid || expected_status.size() != 0) begin
         @(posedge clock);
         #1;
      end
   endtask

   // Registers are only written with the block idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : run_test
      int                    ph;
      int                    count;
      logic [HOUR_W-1:0]     h;
      logic [MINUTE_W-1:0]   m;
      logic [TIMEOUT_W-1:0]  to;
      logic [DEBOUNCE_W-1:0] db;
      logic [CSR_DATA_W-1:0] junk;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items, first under the reset register values (feed at 08:00,
      // long timeout, 50 ms debounce).
      queue_item(make_event(KIND_TICK, 0, 0, 1'b0), 1'b0);
      // Manual request in auto mode is rejected.
      queue_item(make_event(KIND_MANUAL, 0, 0, 1'b1), 1'b0);
      // Hall edge with the motor stopped is dropped.
      queue_item(make_event(KIND_HALL, 0, 0, 1'b0), 1'b0);
      queue_item(make_event(KIND_MANUAL, 0, 0, 1'b0), 1'b0);
      // A second start while running does nothing.
      queue_item(make_event(KIND_MANUAL, 0, 0, 1'b0), 1'b0);
      // Hall edge inside the debounce window.
      queue_item(make_event(KIND_HALL, 0, 0, 1'b0), 1'b0);
      // Scheduled match while running only marks the day as fed.
      queue_item(make_event(KIND_MINUTE, 8, 0, 1'b1), 1'b0);
      // All-ones time fields, which do not match the 08:00 feed time.
      queue_item(make_event(KIND_MINUTE, 31, 63, 1'b1), 1'b0);

      // Short timeout and debounce so stops come within a few ticks, and a
      // midnight feed time.
      write_reg(CSR_FEED_HOUR, '0);
      write_reg(CSR_FEED_MINUTE, '0);
      write_reg(CSR_TIMEOUT, 20'd3);
      write_reg(CSR_DEBOUNCE, 20'd2);
      sched_hour = '0;
      sched_minute = '0;

      // Accepted hall edge, then the next tick stops the motor.
      queue_item(make_event(KIND_TICK, 0, 0, 1'b0), 1'b0);
      queue_item(make_event(KIND_TICK, 0, 0, 1'b0), 1'b0);
      queue_item(make_event(KIND_HALL, 0, 0, 1'b0), 1'b0);
      queue_item(make_event(KIND_TICK, 0, 0, 1'b0), 1'b0);
      // Midnight while already fed clears only; the next midnight starts the
      // motor on the 00:00 schedule and clears in the same item.
      queue_item(make_event(KIND_MINUTE, 0, 0, 1'b1), 1'b0);
      queue_item(make_event(KIND_MINUTE, 0, 0, 1'b1), 1'b0);
      // Hall stop and timeout due on the same tick: the hall stop wins.
      queue_item(make_event(KIND_TICK, 0, 0, 1'b0), 1'b0);
      queue_item(make_event(KIND_TICK, 0, 0, 1'b0), 1'b0);
      queue_item(make_event(KIND_TICK, 0, 0, 1'b0), 1'b0);
      queue_item(make_event(KIND_HALL, 0, 0, 1'b0), 1'b0);
      queue_item(make_event(KIND_TICK, 0, 0, 1'b0), 1'b0);
      // Timeout stop once the run time goes past the limit.
      queue_item(make_event(KIND_MANUAL, 0, 0, 1'b0), 1'b0);
      repeat (4) queue_item(make_event(KIND_TICK, 0, 0, 1'b0), 1'b0);

      // Random phases. Each one picks its register values, then its idling
      // pattern, then runs feed sequences until it has queued enough items.
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         h = HOUR_W'($urandom_range(0, 23));
         m = MINUTE_W'($urandom_range(0, 59));
         to = TIMEOUT_W'($urandom_range(2, 12));
         db = DEBOUNCE_W'($urandom_range(0, 6));
         case (ph)
            0: begin
               h = '0;
               m = '0;
               to = TIMEOUT_W'(1);
               db = '0;
            end
            1: begin
               h = HOUR_W'(23);
               m = MINUTE_W'(59);
               to = '1;
               db = DEBOUNCE_W'(3);
            end
            2: db = '1;
            4: begin
               h = '1;
               m = '1;
            end
            default: ;
         endcase
         // Late phases also set the unused upper bits of the data word.
         junk = (ph >= 6) ? CSR_DATA_W'($urandom) : '0;
         write_reg(CSR_FEED_HOUR, (junk << HOUR_W) | h);
         write_reg(CSR_FEED_MINUTE, (junk << MINUTE_W) | m);
         write_reg(CSR_TIMEOUT, to);
         write_reg(CSR_DEBOUNCE, (junk << DEBOUNCE_W) | db);
         if (ph == 3) begin
            write_reg(CSR_UNUSED_LOW, CSR_DATA_W'($urandom));
            write_reg(CSR_UNUSED_TOP, CSR_DATA_W'($urandom));
         end
         sched_hour = h;
         sched_minute = m;

         case (ph / 2)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 65;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 65;
            end
            default: begin
               send_idle_pct = 9;
               stall_pct = 9;
            end
         endcase

         count = 0;
         while (count < RANDOM_PER_PHASE) begin
            feed_sequence(count);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_status.size() != 0) begin
         report_error("results still outstanding at end of run");
      end
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
